// File: hdl/lkp_pkg.sv
// Shared types, constants and keyframe helpers for the LED keyframe pulse generator.
// Used by every module of the block; depends on nothing else.

package lkp_pkg;

    localparam int LKP_NUM_STEPS = 4;

    localparam int BRIGHT_W = 8;
    localparam int PHASE_W  = 3;
    localparam int DUR_W    = 16;
    localparam int NUM_W    = DUR_W + BRIGHT_W;
    localparam int CNT_W    = $clog2(BRIGHT_W + 1);

    localparam logic [PHASE_W-1:0] REST_PHASE = 3'd4;

    localparam logic [31:0] TARGETS_RESET   = 32'h00C8_00FF;
    localparam logic [63:0] DURATIONS_RESET = 64'h0096_0050_0050_0064;
    localparam logic [15:0] PERIOD_RESET    = 16'd1000;

    typedef enum logic [1:0] {
        REG_TARGETS   = 2'd0,
        REG_DURATIONS = 2'd1,
        REG_PERIOD    = 2'd2
    } lkp_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic advance;
        logic rest;
        logic mul;
        logic div_start;
        logic finish;
        logic emit;
    } lkp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
        logic can_advance;
        logic in_ramp;
        logic div_busy;
        logic out_free;
    } lkp_status_t;

    function automatic logic [BRIGHT_W-1:0] key_target(input logic [31:0] targets,
                                                      input logic [1:0]  k);
        return targets[k*8 +: 8];
    endfunction

    // A zero duration counts as one millisecond.
    function automatic logic [DUR_W-1:0] key_duration(input logic [63:0] durations,
                                                     input logic [1:0]  k);
        logic [DUR_W-1:0] d;
        d = durations[k*16 +: 16];
        return (d == '0) ? DUR_W'(1) : d;
    endfunction

endpackage

// File: hdl/lkp_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Uses lkp_pkg; instantiated by lkp_datapath.

module lkp_divider
    import lkp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [DUR_W-1:0]    den,
    output logic                busy,
    output logic [BRIGHT_W-1:0] quot
);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DUR_W-1:0]    rem_reg;
    logic [BRIGHT_W-1:0] low_reg;
    logic [BRIGHT_W-1:0] quot_reg;

    logic [DUR_W:0]      trial;
    logic [DUR_W:0]      diff;
    logic                fits;

    // The caller guarantees num < den * 2**BRIGHT_W, so the upper part starts below den.
    assign trial = {rem_reg, low_reg[BRIGHT_W-1]};
    assign fits  = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(BRIGHT_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[NUM_W-1:BRIGHT_W];
            low_reg <= num[BRIGHT_W-1:0];
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
            low_reg  <= {low_reg[BRIGHT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[BRIGHT_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// File: hdl/lkp_datapath.sv
// Datapath: beat state, keyframe walk, ramp multiply, divider and output register.
// Uses lkp_pkg and lkp_divider; driven by commands from lkp_ctrl.

module lkp_datapath
    import lkp_pkg::*;
#(
    parameter int NUM_STEPS = LKP_NUM_STEPS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lkp_cmd_t            cmd,
    output lkp_status_t         status,
    input  logic [31:0]         step_targets,
    input  logic [63:0]         step_durations,
    input  logic [15:0]         beat_period,
    input  logic                tick_active,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [BRIGHT_W-1:0] m_brightness,
    output logic [PHASE_W-1:0]  m_phase
);

    logic                active_reg;
    logic                running_reg;
    logic [PHASE_W-1:0]  idx_reg;
    logic [DUR_W-1:0]    elapsed_reg;
    logic [DUR_W-1:0]    beat_reg;
    logic [BRIGHT_W-1:0] start_reg;
    logic [NUM_W-1:0]    prod_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic                out_valid_reg;
    logic [BRIGHT_W-1:0] out_bright_reg;
    logic [PHASE_W-1:0]  out_phase_reg;

    logic [DUR_W-1:0]    cur_dur;
    logic [BRIGHT_W-1:0] cur_tgt;
    logic                in_ramp;
    logic [NUM_W-1:0]    num;
    logic [DUR_W-1:0]    beat_inc;
    logic                div_busy;
    logic [BRIGHT_W-1:0] quot;

    assign cur_dur  = key_duration(step_durations, idx_reg[1:0]);
    assign cur_tgt  = key_target(step_targets, idx_reg[1:0]);
    assign in_ramp  = idx_reg < PHASE_W'(NUM_STEPS);
    assign beat_inc = (beat_reg == '1) ? beat_reg : beat_reg + DUR_W'(1);

    // Second ramp term is added as the dividend is loaded.
    assign num = prod_reg + NUM_W'(elapsed_reg) * NUM_W'(cur_tgt);

    lkp_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num),
        .den     (cur_dur),
        .busy    (div_busy),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            idx_reg     <= REST_PHASE;
            elapsed_reg <= '0;
            beat_reg    <= '0;
            start_reg   <= '0;
        end else if (cmd.load) begin
            if (!tick_active || !running_reg) begin
                running_reg <= tick_active;
                idx_reg     <= tick_active ? PHASE_W'(0) : REST_PHASE;
                elapsed_reg <= '0;
                beat_reg    <= '0;
                start_reg   <= '0;
            end
        end else if (cmd.advance) begin
            start_reg   <= cur_tgt;
            elapsed_reg <= elapsed_reg - cur_dur;
            idx_reg     <= idx_reg + PHASE_W'(1);
        end else if (cmd.rest) begin
            idx_reg  <= REST_PHASE;
            beat_reg <= beat_inc;
            if (beat_reg >= beat_period) begin
                running_reg <= 1'b0;
            end
        end else if (cmd.finish) begin
            beat_reg    <= beat_inc;
            elapsed_reg <= (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + DUR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            active_reg <= tick_active;
            bright_reg <= '0;
            phase_reg  <= REST_PHASE;
        end
        if (cmd.mul) begin
            prod_reg <= NUM_W'(start_reg) * NUM_W'(cur_dur - elapsed_reg);
        end
        if (cmd.finish) begin
            bright_reg <= quot;
            phase_reg  <= idx_reg;
        end
        if (cmd.emit) begin
            out_bright_reg <= bright_reg;
            out_phase_reg  <= phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.active      = active_reg;
    assign status.can_advance = in_ramp && (elapsed_reg >= cur_dur);
    assign status.in_ramp     = in_ramp;
    assign status.div_busy    = div_busy;
    assign status.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid     = out_valid_reg;
    assign m_brightness = out_bright_reg;
    assign m_phase      = out_phase_reg;

    a_ramp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> (in_ramp && elapsed_reg < cur_dur))
        else $error("ramp started with elapsed time past the keyframe duration");

    a_idle_at_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (idx_reg == REST_PHASE))
        else $error("beat stopped outside the rest phase");

    a_rest_is_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_phase_reg == REST_PHASE) |-> (out_bright_reg == '0))
        else $error("non-zero brightness reported during rest");

endmodule

// File: hdl/lkp_ctrl.sv
// Controller state machine sequencing one tick through the datapath.
// Uses lkp_pkg; talks to lkp_datapath through command and status structs.

module lkp_ctrl
    import lkp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  lkp_status_t status,
    output lkp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_FINISH,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!status.active) begin
                    state_next = ST_EMIT;
                end else if (status.can_advance) begin
                    cmd.advance = 1'b1;
                end else if (!status.in_ramp) begin
                    cmd.rest   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// File: hdl/led_keyframe_pulse_generator_unit.sv
// Top level of the LED keyframe pulse generator: configuration registers and stream ports.
// Uses lkp_pkg, lkp_ctrl and lkp_datapath.

// The block turns a stream of millisecond ticks into LED brightness values.
// Each item on the s_ channel is one tick and carries the active level in
// s_tdata bit 0. Every accepted item gives exactly one item on the m_ channel
// with the brightness in m_tdata[7:0] and the keyframe index in m_tdata[10:8],
// where index 4 means rest or inactive.
// While active, a beat plays the four keyframes held in the step_targets and
// step_durations registers, each ramping linearly from the previous target,
// then rests until beat_period milliseconds have gone by. An inactive tick
// gives zero brightness and rearms the beat for the next active tick.
// Items are taken one at a time. A ramp tick goes from acceptance to its
// result through the walk past elapsed keyframes, product, divider load, the
// serial divider, finish and emit; rest and inactive ticks skip the product,
// divider and finish steps. The next item can be accepted as the result
// appears. The result sits in an output register, so the next item is
// accepted while it waits; if the receiver stalls, the following result
// waits in the datapath and input is held off until the output register
// frees. Reset (aresetn low, synchronous) restores the register defaults,
// empties the output register and disarms the beat. Registers sit at byte
// addresses 0, 8 and 16; the user must see they are written only while the
// block is idle, as the block itself does not enforce this.

module led_keyframe_pulse_generator_unit
    import lkp_pkg::*;
#(
    parameter int NUM_STEPS = LKP_NUM_STEPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] active, [7:1] zero
    // Brightness output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] brightness, [10:8] phase, [15:11] zero
);

    logic [31:0] targets_reg;
    logic [63:0] durations_reg;
    logic [15:0] period_reg;

    lkp_reg_t            reg_sel;
    logic                cfg_write;
    lkp_cmd_t            cmd;
    lkp_status_t         status;
    logic [BRIGHT_W-1:0] brightness;
    logic [PHASE_W-1:0]  phase;

    // Registers are spaced eight bytes apart, so the index is paddr[4:3].
    assign reg_sel   = lkp_reg_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            targets_reg   <= TARGETS_RESET;
            durations_reg <= DURATIONS_RESET;
            period_reg    <= PERIOD_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_TARGETS:   targets_reg   <= pwdata[31:0];
                REG_DURATIONS: durations_reg <= pwdata;
                REG_PERIOD:    period_reg    <= pwdata[15:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TARGETS:   prdata = {32'd0, targets_reg};
            REG_DURATIONS: prdata = durations_reg;
            REG_PERIOD:    prdata = {48'd0, period_reg};
            default:       prdata = '0;
        endcase
    end

    lkp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lkp_datapath #(
        .NUM_STEPS (NUM_STEPS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .step_targets   (targets_reg),
        .step_durations (durations_reg),
        .beat_period    (period_reg),
        .tick_active    (s_tdata[0]),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_brightness   (brightness),
        .m_phase        (phase)
    );

    assign m_tdata = {5'd0, phase, brightness};

endmodule
